// ===== design/arra_pkg.sv =====
// ----------------------------------------------------------------------------
// arra_pkg: shared types and constants for the audio ring rate adapter
// Holds the fixed field widths, the reset latency target, the reciprocal used
// for the divide-by-ten step and the control structs between the modules.
// ----------------------------------------------------------------------------
package arra_pkg;

  // Fixed field widths.
  localparam int SAMPLE_W  = 16;
  localparam int FRAME_W   = 32;
  localparam int BURST_W   = 7;
  localparam int LATENCY_W = 16;
  localparam int DATA_W    = 40;

  // Default latency target in frames.
  localparam logic [LATENCY_W-1:0] LATENCY_RESET = 16'd2000;

  // Divide by ten as a multiply by ceil(2^35 / 10), exact for any 32-bit value.
  localparam int              DIV_W       = 32;
  localparam logic [DIV_W-1:0] RECIP_10    = 32'hCCCCCCCD;
  localparam int              RECIP_SHIFT = 35;

  // Operation codes carried in tuser on the input side.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // Pointer advance strobes from the sequencer.
  typedef struct packed {
    logic wr_step;
    logic rd_step;
  } ptr_cmd_t;

  // Burst size result from the calculation pipeline.
  typedef struct packed {
    logic               valid;
    logic               empty;
    logic [BURST_W-1:0] count;
  } burst_res_t;

endpackage

// ===== design/arra_ram.sv =====
// ----------------------------------------------------------------------------
// arra_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered and holds its
// value while no read is enabled.
// ----------------------------------------------------------------------------
module arra_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/arra_ring_ptrs.sv =====
// ----------------------------------------------------------------------------
// arra_ring_ptrs: write and read positions of the ring
// Keeps period and slot counters for both sides together with the linear
// store addresses, and registers the count of frames available to read.
// ----------------------------------------------------------------------------
module arra_ring_ptrs
  import arra_pkg::*;
#(
  parameter int PERIOD_FRAMES = 16,
  parameter int RING_PERIODS  = 1024
) (
  input  logic                                             clk,
  input  logic                                             rst,
  input  ptr_cmd_t                                         cmd,
  output logic [$clog2(RING_PERIODS*PERIOD_FRAMES)-1:0]    waddr,
  output logic [$clog2(RING_PERIODS*PERIOD_FRAMES)-1:0]    raddr,
  output logic [$clog2(RING_PERIODS*PERIOD_FRAMES+1)-1:0]  avail
);

  localparam int DEPTH = RING_PERIODS * PERIOD_FRAMES;
  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SW    = $clog2(PERIOD_FRAMES);
  localparam int PW    = $clog2(RING_PERIODS);

  localparam logic [SW-1:0] SLOT_LAST   = SW'(PERIOD_FRAMES - 1);
  localparam logic [PW-1:0] PERIOD_LAST = PW'(RING_PERIODS - 1);
  localparam logic [AW-1:0] ADDR_LAST   = AW'(DEPTH - 1);
  localparam logic [AW:0]   DEPTH_EXT   = (AW+1)'(DEPTH);

  logic [SW-1:0] write_slot, read_slot;
  logic [PW-1:0] write_period, read_period;
  logic [AW:0]   addr_diff, addr_wrap;

  // Advance the write and read positions.
  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot   <= '0;
      write_period <= '0;
      waddr        <= '0;
      read_slot    <= '0;
      read_period  <= '0;
      raddr        <= '0;
    end else begin
      if (cmd.wr_step) begin
        if (write_slot == SLOT_LAST) begin
          write_slot   <= '0;
          write_period <= (write_period == PERIOD_LAST) ? '0 : write_period + 1'b1;
        end else begin
          write_slot <= write_slot + 1'b1;
        end
        waddr <= (waddr == ADDR_LAST) ? '0 : waddr + 1'b1;
      end
      if (cmd.rd_step) begin
        if (read_slot == SLOT_LAST) begin
          read_slot   <= '0;
          read_period <= (read_period == PERIOD_LAST) ? '0 : read_period + 1'b1;
        end else begin
          read_slot <= read_slot + 1'b1;
        end
        raddr <= (raddr == ADDR_LAST) ? '0 : raddr + 1'b1;
      end
    end
  end

  // The distance between the addresses around the ring is the available
  // count, except that matching periods always mean an empty ring.
  assign addr_diff = {1'b0, waddr} - {1'b0, raddr};
  assign addr_wrap = addr_diff[AW] ? addr_diff + DEPTH_EXT : addr_diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      avail <= '0;
    end else if (read_period == write_period) begin
      avail <= '0;
    end else begin
      avail <= CNT_W'(addr_wrap[AW-1:0]);
    end
  end

endmodule

// ===== design/arra_burst_calc.sv =====
// ----------------------------------------------------------------------------
// arra_burst_calc: burst size pipeline
// Three stages: latency error and its magnitude, multiply by the reciprocal of
// ten, then sign, add to the expected count and cap at available and maximum.
// ----------------------------------------------------------------------------
module arra_burst_calc
  import arra_pkg::*;
#(
  parameter int CNT_W     = 15,
  parameter int MAX_BURST = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [BURST_W-1:0]   expected,
  input  logic [LATENCY_W-1:0] target,
  input  logic [CNT_W-1:0]     avail,
  output burst_res_t           res
);

  localparam int BASE_W = (CNT_W > LATENCY_W) ? CNT_W : LATENCY_W;
  localparam int DW     = BASE_W + 2;
  localparam int BW     = DW + 1;

  localparam logic signed [BW-1:0] MAX_S = BW'(MAX_BURST);

  logic signed [DW-1:0] diff, diff_abs;
  logic                 v1, v2;
  logic                 neg1, neg2;
  logic [DIV_W-1:0]     mag1;
  logic [2*DIV_W-1:0]   prod2;
  logic [BURST_W-1:0]   exp1, exp2;
  logic [CNT_W-1:0]     avail1, avail2;
  logic signed [BW-1:0] quot_s, sum_s, cap_a, cap_m;

  // Stage one: signed latency error and its magnitude.
  assign diff = $signed({{(DW-CNT_W){1'b0}}, avail})
              - $signed({{(DW-BURST_W){1'b0}}, expected})
              - $signed({{(DW-LATENCY_W){1'b0}}, target});
  assign diff_abs = diff[DW-1] ? -diff : diff;

  always_ff @(posedge clk) begin
    neg1   <= diff[DW-1];
    mag1   <= {{(DIV_W-DW){1'b0}}, diff_abs};
    exp1   <= expected;
    avail1 <= avail;
  end

  // Stage two: quotient by ten through the reciprocal.
  always_ff @(posedge clk) begin
    prod2  <= mag1 * RECIP_10;
    neg2   <= neg1;
    exp2   <= exp1;
    avail2 <= avail1;
  end

  // Stage three: restore the sign (truncation toward zero) and cap.
  assign quot_s = $signed({1'b0, prod2[RECIP_SHIFT +: DW]});
  assign sum_s  = $signed({{(BW-BURST_W){1'b0}}, exp2}) + (neg2 ? -quot_s : quot_s);
  assign cap_a  = (sum_s > $signed({{(BW-CNT_W){1'b0}}, avail2}))
                ? $signed({{(BW-CNT_W){1'b0}}, avail2}) : sum_s;
  assign cap_m  = (cap_a > MAX_S) ? MAX_S : cap_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      v1        <= start;
      v2        <= v1;
      res.valid <= v2;
    end
    res.empty <= cap_m[BW-1] || (cap_m == '0);
    res.count <= (cap_m[BW-1] || (cap_m == '0)) ? '0 : cap_m[BURST_W-1:0];
  end

endmodule

// ===== design/audio_ring_rate_adapter.sv =====
// ----------------------------------------------------------------------------
// audio_ring_rate_adapter: stereo audio ring with latency-steered read bursts
// Write words store one frame each, one per cycle while idle; a read word sizes
// a burst from the buffered amount and the latency target, then streams it out.
// ----------------------------------------------------------------------------
// A write word is accepted and stored in the same cycle, back to back while idle.
// A read word occupies the block through burst sizing (start register and the
// three-stage divide-by-ten pipeline), then streams one frame per cycle from the
// frame RAM read port while the output is taken. An empty burst gives its single
// no-data word once sizing is done.
// Reset clears pointers and sets the latency target to LATENCY_RESET; the frame RAM is
// not cleared and needs no clearing pass.
module audio_ring_rate_adapter
  import arra_pkg::*;
#(
  parameter int PERIOD_FRAMES = 16,
  parameter int RING_PERIODS  = 1024,
  parameter int MAX_BURST     = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  // Configuration: target_latency_frames.
  input  logic                 cfg_we,
  input  logic [LATENCY_W-1:0] cfg_wdata,
  // Input stream.
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // s_tdata: left_sample[15:0], right_sample[31:16], expected_frames[38:32], zero[39].
  input  logic [DATA_W-1:0]    s_tdata,
  // s_tuser: operation[0].
  input  logic [0:0]           s_tuser,
  // Output stream.
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // m_tdata: out_left[15:0], out_right[31:16], burst_count[38:32], zero[39].
  output logic [DATA_W-1:0]    m_tdata,
  // m_tuser: no_data[0].
  output logic [0:0]           m_tuser,
  output logic                 m_tlast
);

  localparam int DEPTH = RING_PERIODS * PERIOD_FRAMES;
  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_EMPTY,
    ST_READ
  } state_t;

  state_t               state;
  logic [LATENCY_W-1:0] target;
  logic [BURST_W-1:0]   expected;
  logic [BURST_W-1:0]   burst_cnt;
  logic [BURST_W-1:0]   remaining;
  logic                 calc_start;

  ptr_cmd_t             cmd;
  burst_res_t           res;
  logic [AW-1:0]        waddr, raddr;
  logic [CNT_W-1:0]     avail;
  logic [FRAME_W-1:0]   rdata;
  logic                 ram_re;
  logic                 wr_acc, rd_acc, out_free, out_load;
  logic                 issue_first, issue_next;

  // Handshake decode and read issue.
  assign s_tready    = (state == ST_IDLE);
  assign wr_acc      = s_tvalid && s_tready && (s_tuser[0] == OP_WRITE);
  assign rd_acc      = s_tvalid && s_tready && (s_tuser[0] == OP_READ);
  assign out_free    = !m_tvalid || m_tready;
  assign out_load    = ((state == ST_EMPTY) || (state == ST_READ)) && out_free;
  assign issue_first = (state == ST_CALC) && res.valid && !res.empty;
  assign issue_next  = (state == ST_READ) && out_free && (remaining != BURST_W'(1));
  assign ram_re      = issue_first || issue_next;

  always_comb begin
    cmd.wr_step = wr_acc;
    cmd.rd_step = ram_re;
  end

  arra_ring_ptrs #(
    .PERIOD_FRAMES(PERIOD_FRAMES),
    .RING_PERIODS (RING_PERIODS)
  ) u_ptrs (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .waddr(waddr),
    .raddr(raddr),
    .avail(avail)
  );

  arra_burst_calc #(
    .CNT_W    (CNT_W),
    .MAX_BURST(MAX_BURST)
  ) u_calc (
    .clk     (clk),
    .rst     (rst),
    .start   (calc_start),
    .expected(expected),
    .target  (target),
    .avail   (avail),
    .res     (res)
  );

  // Frame store: left sample in the low half, right in the high half.
  arra_ram #(
    .WIDTH(FRAME_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (wr_acc),
    .waddr(waddr),
    .wdata({s_tdata[2*SAMPLE_W-1:SAMPLE_W], s_tdata[SAMPLE_W-1:0]}),
    .re   (ram_re),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Sequencer with the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      target     <= LATENCY_RESET;
      calc_start <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        target <= cfg_wdata;
      end
      calc_start <= rd_acc;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (rd_acc) begin
            expected <= s_tdata[2*SAMPLE_W +: BURST_W];
            state    <= ST_CALC;
          end
        end
        ST_CALC: begin
          if (res.valid) begin
            if (res.empty) begin
              state <= ST_EMPTY;
            end else begin
              burst_cnt <= res.count;
              remaining <= res.count;
              state     <= ST_READ;
            end
          end
        end
        ST_EMPTY: begin
          if (out_free) begin
            m_tdata  <= '0;
            m_tuser  <= 1'b1;
            m_tlast  <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        ST_READ: begin
          if (out_free) begin
            m_tdata   <= {{(DATA_W-FRAME_W-BURST_W){1'b0}}, burst_cnt, rdata};
            m_tuser   <= 1'b0;
            m_tlast   <= (remaining == BURST_W'(1));
            remaining <= remaining - 1'b1;
            if (remaining == BURST_W'(1)) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // An empty-burst word always closes its burst.
  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tlast)
    else $error("no-data word without last flag");

  // A frame word carries a nonzero burst count within the maximum.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |->
      (m_tdata[2*SAMPLE_W +: BURST_W] != '0) &&
      (m_tdata[2*SAMPLE_W +: BURST_W] <= BURST_W'(MAX_BURST)))
    else $error("burst count out of range");

  // While streaming, at least one frame remains to send.
  a_remaining: assert property (@(posedge clk) disable iff (rst)
    state == ST_READ |-> remaining != '0)
    else $error("read state with no frames left");

  // The store is never written and read in the same cycle.
  a_port_excl: assert property (@(posedge clk) disable iff (rst)
    !(wr_acc && ram_re))
    else $error("frame store write and read overlap");

  // The sizing result arrives only while the sequencer waits for it.
  a_res_in_calc: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> state == ST_CALC)
    else $error("burst size result outside calculation wait");

endmodule

// ===== sim/ring_mirror_pkg.sv =====
// ----------------------------------------------------------------------------
// ring_mirror_pkg: behavioral mirror of the audio ring rate adapter
// Keeps its own copy of the frame ring, the read and write positions and the
// latency target. It works out the read bursts that each accepted word causes
// and checks every output word against the oldest frame still due.
// ----------------------------------------------------------------------------
package ring_mirror_pkg;
  import arra_pkg::*;

  localparam int PERIOD_LEN = 16;
  localparam int RING_LEN   = 1024;
  localparam int RING_DEPTH = PERIOD_LEN * RING_LEN;
  localparam int BURST_CAP  = 64;
  localparam int PULL_DIV   = 10;

  // One output word as the block should present it.
  typedef struct packed {
    logic [SAMPLE_W-1:0] left;
    logic [SAMPLE_W-1:0] right;
    logic                last;
    logic                no_data;
    logic [BURST_W-1:0]  count;
  } ring_word_t;

  class ring_mirror;
    bit [FRAME_W-1:0] frames [RING_DEPTH];
    int wr_period, wr_slot, rd_period, rd_slot;
    int latency_target;
    ring_word_t frames_due [$];
    int errors, writes_seen, reads_seen, empty_bursts, words_checked;

    function new();
      wr_period = 0;
      wr_slot = 0;
      rd_period = 0;
      rd_slot = 0;
      latency_target = int'(LATENCY_RESET);
      errors = 0;
      writes_seen = 0;
      reads_seen = 0;
      empty_bursts = 0;
      words_checked = 0;
    endfunction

    function void set_latency(logic [LATENCY_W-1:0] value);
      latency_target = int'(value);
    endfunction

    function void flag(string what);
      errors++;
      if (errors <= 10) begin
        $display("ERROR: %s", what);
      end
    endfunction

    // Frames between the read and write positions; equal periods count as empty.
    function int buffered_frames();
      int between;
      if (rd_period == wr_period) begin
        return 0;
      end
      if (rd_period < wr_period) begin
        between = wr_period - rd_period - 1;
      end else begin
        between = wr_period + RING_LEN - rd_period - 1;
      end
      return (PERIOD_LEN - rd_slot) + between * PERIOD_LEN + wr_slot;
    endfunction

    // Apply one accepted input word and queue the output words it causes.
    function void note_word(logic op, logic [SAMPLE_W-1:0] left,
                            logic [SAMPLE_W-1:0] right, logic [BURST_W-1:0] want);
      int avail;
      int size;
      int i;
      int addr;
      ring_word_t w;
      if (op == OP_WRITE) begin
        frames[wr_period * PERIOD_LEN + wr_slot] = {right, left};
        writes_seen++;
        wr_slot++;
        if (wr_slot == PERIOD_LEN) begin
          wr_slot = 0;
          wr_period = (wr_period + 1) % RING_LEN;
        end
        return;
      end
      reads_seen++;
      avail = buffered_frames();
      // Signed division truncates toward zero, as the steering rule needs.
      size = int'(want) + (avail - int'(want) - latency_target) / PULL_DIV;
      if (size > avail) begin
        size = avail;
      end
      if (size > BURST_CAP) begin
        size = BURST_CAP;
      end
      if (size <= 0) begin
        empty_bursts++;
        w = '0;
        w.last = 1'b1;
        w.no_data = 1'b1;
        frames_due.push_back(w);
        return;
      end
      for (i = 0; i < size; i++) begin
        addr = rd_period * PERIOD_LEN + rd_slot;
        w.left = frames[addr][SAMPLE_W-1:0];
        w.right = frames[addr][FRAME_W-1:SAMPLE_W];
        w.last = (i == size - 1);
        w.no_data = 1'b0;
        w.count = BURST_W'(size);
        frames_due.push_back(w);
        rd_slot++;
        if (rd_slot == PERIOD_LEN) begin
          rd_slot = 0;
          rd_period = (rd_period + 1) % RING_LEN;
        end
      end
    endfunction

    // Compare one accepted output word with the oldest frame due.
    function void check_word(logic [SAMPLE_W-1:0] left, logic [SAMPLE_W-1:0] right,
                             logic last, logic no_data, logic [BURST_W-1:0] count);
      ring_word_t want;
      if (frames_due.size() == 0) begin
        flag($sformatf("word with none due: left %h right %h last %b no_data %b count %0d",
                       left, right, last, no_data, count));
        return;
      end
      want = frames_due.pop_front();
      words_checked++;
      if (left !== want.left || right !== want.right || last !== want.last ||
          no_data !== want.no_data || count !== want.count) begin
        flag($sformatf({"word %0d: expected left %h right %h last %b no_data %b count %0d,",
                        " got left %h right %h last %b no_data %b count %0d"},
                       words_checked, want.left, want.right, want.last, want.no_data,
                       want.count, left, right, last, no_data, count));
      end
    endfunction
  endclass

endpackage

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb: stream-level test of the audio ring rate adapter
// Drives write and read-request words with random bursts and gaps, stalls the
// output on a shifting pattern plus one long hold-off, and checks every
// output word against a behavioral mirror across several latency targets.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import arra_pkg::*;
  import ring_mirror_pkg::*;

  localparam int CYCLE_LIMIT     = 2000000;
  localparam int SETTLE_CYCLES   = 16;
  localparam int HOLD_OFF_CYCLES = 400;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [LATENCY_W-1:0] cfg_wdata;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [DATA_W-1:0]    s_tdata;
  logic [0:0]           s_tuser;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [DATA_W-1:0]    m_tdata;
  logic [0:0]           m_tuser;
  logic                 m_tlast;

  ring_mirror board;
  bit         hold_off_req;
  int         burst_left;
  int         cycle_count;

  // Corner sample values for the directed writes.
  logic [SAMPLE_W-1:0] corner [6] = '{16'h8000, 16'h7FFF, 16'h0000,
                                     16'hFFFF, 16'h5555, 16'hAAAA};

  audio_ring_rate_adapter u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Offer one word, with a random gap whenever a sender burst runs out.
  task automatic send_word(logic op, logic [SAMPLE_W-1:0] left,
                           logic [SAMPLE_W-1:0] right, logic [BURST_W-1:0] want);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= {1'b0, want, right, left};
    s_tuser <= op;
    do @(posedge clk); while (!s_tready);
    board.note_word(op, left, right, want);
  endtask

  task automatic send_random(int read_pct);
    if ($urandom_range(0, 99) < read_pct) begin
      send_word(OP_READ, SAMPLE_W'($urandom), SAMPLE_W'($urandom),
                BURST_W'($urandom_range(0, 127)));
    end else begin
      send_word(OP_WRITE, SAMPLE_W'($urandom), SAMPLE_W'($urandom), BURST_W'($urandom));
    end
  endtask

  // Stop offering and wait until every due word has come out and the block is idle.
  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (board.frames_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_target(logic [LATENCY_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    board.set_latency(value);
  endtask

  // Output ready: modes of no, light and heavy stalling, plus the long hold-off.
  initial begin
    int stall_left;
    int mode_left;
    int stall_pct;
    m_tready = 1'b0;
    stall_left = 0;
    mode_left = 0;
    stall_pct = 0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        mode_left = $urandom_range(64, 256);
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 15;
          default: stall_pct = 50;
        endcase
      end
      mode_left--;
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
      end else if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        m_tready <= 1'b0;
        stall_left = $urandom_range(0, 3);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Check each output word taken.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      board.check_word(m_tdata[15:0], m_tdata[31:16], m_tlast, m_tuser[0], m_tdata[38:32]);
    end
  end

  // Run limit.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb failed");
    $finish;
  end

  initial begin
    int i;
    logic [LATENCY_W-1:0] mid_target;
    board = new();
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    hold_off_req = 1'b0;
    burst_left = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Empty ring at the reset target, then corner samples across a period edge.
    send_word(OP_READ, '0, '0, 7'd0);
    send_word(OP_READ, 16'hFFFF, 16'hFFFF, 7'd127);
    for (i = 0; i < 18; i++) begin
      send_word(OP_WRITE, corner[i % 6], corner[(i + 3) % 6], BURST_W'(i));
    end
    // Data is buffered but far below the target: still an empty burst.
    send_word(OP_READ, '0, '0, 7'd64);
    settle();

    // Zero target: a one-frame burst, a burst capped at what is buffered,
    // then a read with the positions in the same period.
    write_target('0);
    send_word(OP_READ, '0, '0, 7'd0);
    send_word(OP_READ, '0, '0, 7'd127);
    send_word(OP_READ, '0, '0, 7'd1);

    // Fill, ask for a full burst and hold the output off while input keeps coming.
    for (i = 0; i < 70; i++) begin
      send_random(0);
    end
    send_word(OP_READ, SAMPLE_W'($urandom), SAMPLE_W'($urandom), 7'd127);
    hold_off_req = 1'b1;
    for (i = 0; i < 30; i++) begin
      send_random(25);
    end
    settle();

    // A moderate random target.
    mid_target = LATENCY_W'($urandom_range(1, 300));
    write_target(mid_target);
    for (i = 0; i < 40; i++) begin
      send_random(25);
    end
    settle();

    // Largest target: every read comes back empty.
    write_target('1);
    for (i = 0; i < 16; i++) begin
      send_random(40);
    end
    settle();

    // Back to the reset target; with little buffered, reads come back empty.
    write_target(LATENCY_RESET);
    for (i = 0; i < 20; i++) begin
      send_random(15);
    end
    settle();

    if (board.frames_due.size() != 0) begin
      board.flag($sformatf("%0d words still due at the end", board.frames_due.size()));
    end
    $display("Covered %0d frame writes and %0d read requests (%0d empty), %0d words checked.",
             board.writes_seen, board.reads_seen, board.empty_bursts, board.words_checked);
    $display("Targets 2000, 0, %0d and 65535, with one long output hold-off stalling input.",
             mid_target);
    if (board.errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
